// File: rtl/core/spq_pkg.sv
package spq_pkg;

  // Queue geometry.
  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int CNT_W         = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int PRIO_W   = 8;
  localparam int FILL_W   = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [DATA_W-1:0]        data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef struct packed {
    data_t data;
    prio_t prio;
  } entry_t;

  // Broadcast from the controller to every cell in the row.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctl_t;

endpackage

// File: rtl/core/spq_in_if.sv
interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] data_in;
  logic [PRIO_W-1:0]        priority_in;

  modport source (output valid, output opcode, output data_in, output priority_in,
                  input ready);
  modport sink   (input valid, input opcode, input data_in, input priority_in,
                  output ready);
endinterface

// File: rtl/core/spq_out_if.sv
interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] data_out;
  logic [PRIO_W-1:0]        priority_out;
  logic [FILL_W-1:0]        fill_count;

  modport source (output valid, output status, output data_out, output priority_out,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input data_out, input priority_out,
                  input fill_count, output ready);
endinterface

// File: rtl/core/sorted_priority_queue.sv
// Sorted priority queue of DEPTH entries, smallest priority value first.
//
// Input channel (in_ch): each transfer carries one operation: enqueue,
// dequeue of the head, or peek at the head. Every transfer produces exactly
// one result on the output channel (out_ch) with a status, the head data
// and priority where one is returned, and the fill count after the operation.
//
// The entries live in a row of identical cells, cell 0 holding the head.
// Each cell compares its priority against the incoming one in parallel; on
// an enqueue every cell behind the insertion point takes its left neighbor's
// entry and the cell at the insertion point takes the new one. On a dequeue
// every cell takes its right neighbor's entry. Entries of equal priority
// keep their arrival order because a new entry goes behind them.
//
// The result is registered and valid in the cycle after the input transfer,
// and the block takes one operation every cycle while the receiver does not
// stall: the whole row updates in the accepting cycle, bounded by one priority compare and a two-level select per cell.
// The result register decouples the channels; while the receiver stalls
// the held result blocks only the next input transfer. Reset clears the
// fill count and the result valid; cell contents are not reset, and only
// cells below the fill count are ever read.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  // Handshake and decode.
  logic      in_xfer;
  logic      is_full;
  logic      is_empty;
  cell_ctl_t ctl;

  // Fill count.
  cnt_t count_r;
  cnt_t count_nxt;

  // Result register.
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [ST_W-1:0]  out_status_nxt;
  data_t            out_data_r;
  data_t            out_data_nxt;
  prio_t            out_prio_r;
  prio_t            out_prio_nxt;

  // Cell row.
  entry_t           cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_le;
  logic [DEPTH-1:0] cell_occ;

  // A new operation may enter whenever the result slot is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign is_full  = (count_r == cnt_t'(DEPTH));
  assign is_empty = (count_r == '0);

  assign ctl.enq       = in_xfer && (in_ch.opcode == OP_ENQUEUE) && !is_full;
  assign ctl.deq       = in_xfer && (in_ch.opcode == OP_DEQUEUE) && !is_empty;
  assign ctl.item.data = data_t'(in_ch.data_in);
  assign ctl.item.prio = prio_t'(in_ch.priority_in);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_entry;
      entry_t right_entry;
      logic   left_le;

      assign cell_occ[gi] = (count_r > cnt_t'(gi));

      if (gi == 0) begin : g_head
        // The head has no left neighbor: a new entry that passes it lands here.
        assign left_le    = 1'b1;
        assign left_entry = cell_entry[gi];
      end else begin : g_body
        assign left_le    = cell_le[gi-1];
        assign left_entry = cell_entry[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        // Beyond the tail is nothing; its content after a dequeue is unused.
        assign right_entry = cell_entry[gi];
      end else begin : g_inner
        assign right_entry = cell_entry[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occupied    (cell_occ[gi]),
        .left_le     (left_le),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (cell_entry[gi]),
        .le          (cell_le[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  // Result of the operation being transferred in this cycle.
  always_comb begin
    out_status_nxt = ST_OK;
    out_data_nxt   = '0;
    out_prio_nxt   = '0;
    unique case (in_ch.opcode)
      OP_ENQUEUE: begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_data_nxt = cell_entry[0].data;
          out_prio_nxt = cell_entry[0].prio;
        end
      end
      default: begin
        // Undefined opcode: no effect, plain OK result.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_prio_r   <= out_prio_nxt;
    end
  end

  // The result captures the next fill count, which is the count after the operation.
  logic [FILL_W-1:0] out_fill_r;
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_fill_r <= FILL_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.data_out     = $signed(out_data_r);
  assign out_ch.priority_out = PRIO_W'(out_prio_r);
  assign out_ch.fill_count   = out_fill_r;

  // The fill count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("fill count exceeds queue depth");

  // A successful dequeue removes exactly one entry.
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.deq |=> count_r == $past(count_r) - cnt_t'(1))
    else $error("dequeue did not decrement the fill count");

  // The two front cells stay in priority order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= cnt_t'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("head entry out of priority order");

  // An input stall only ever comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r && !out_ch.ready)
    else $error("input stalled without a pending result");

endmodule

// File: rtl/core/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      left_le,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      le
);

  entry_t entry_r;
  entry_t entry_nxt;

  // This entry stays ahead of a new one of equal or larger priority.
  assign le    = occupied && (entry_r.prio <= ctl.item.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq) begin
      if (!le) begin
        entry_nxt = left_le ? ctl.item : left_entry;
      end
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
